// ===== hdl/ssdg_pkg.sv =====
// Shared types and constants for the spectral sharpen / dehalo gain block.
// No dependencies.
`timescale 1ns / 1ps

package ssdg_pkg;

  localparam int DATA_W     = 24;
  localparam int CORR_W     = 25;
  localparam int PWR_W      = 48;
  localparam int WGT_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int DIV_STEPS  = 30;
  localparam int DIV_W_S    = 49;
  localparam int DIV_W_D    = 55;
  localparam int SQRT_STEPS = 31;
  localparam int QDEPTH_DEF = 4;
  localparam int ADDR_W     = 6;
  localparam int APB_DW     = 64;

  typedef enum logic [2:0] {
    REG_SIGMA_LOW  = 3'd0,
    REG_SIGMA_HIGH = 3'd1,
    REG_SHARPEN    = 3'd2,
    REG_DEHALO     = 3'd3,
    REG_HALO       = 3'd4,
    REG_DEGRID     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [PWR_W-1:0]         sigma_low;
    logic [PWR_W-1:0]         sigma_high;
    logic [PWR_W-1:0]         halo;
    logic signed [GAIN_W-1:0] sharpen_gain;
    logic [GAIN_W-1:0]        dehalo_gain;
    logic                     degrid;
  } cfg_t;

  // queued word: corrected coefficient, grid to add back, power, weights
  typedef struct packed {
    logic signed [CORR_W-1:0] c_re;
    logic signed [CORR_W-1:0] c_im;
    logic signed [DATA_W-1:0] g_re;
    logic signed [DATA_W-1:0] g_im;
    logic [PWR_W-1:0]         p;
    logic [WGT_W-1:0]         sw;
    logic [WGT_W-1:0]         dw;
  } ent_t;

endpackage

// ===== hdl/ssdg_div.sv =====
// Pipelined restoring fraction divider: floor(n * 2^STEPS / d), one quotient bit per stage.
// Saturates to 2^STEPS when n >= d. No package dependency.
`timescale 1ns / 1ps

module ssdg_div #(
  parameter int W     = 49,
  parameter int STEPS = 30
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   n_i,
  input  logic [W-1:0]   d_i,
  output logic [STEPS:0] q_o
);

  logic [W-1:0]     rem_q [STEPS];
  logic [W-1:0]     d_q   [STEPS];
  logic [STEPS-1:0] qb_q  [STEPS];
  logic             ge_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    logic [W-1:0]     rin, din;
    logic [STEPS-1:0] qin;
    logic             gin;
    logic [W:0]       t;
    if (k == 0) begin : g_first
      assign rin = n_i;
      assign din = d_i;
      assign qin = '0;
      assign gin = (n_i >= d_i);
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = d_q[k-1];
      assign qin = qb_q[k-1];
      assign gin = ge_q[k-1];
    end
    assign t = {rin, 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[k]  <= din;
        ge_q[k] <= gin;
        if (t >= {1'b0, din}) begin
          rem_q[k] <= W'(t - {1'b0, din});
          qb_q[k]  <= {qin[STEPS-2:0], 1'b1};
        end else begin
          rem_q[k] <= t[W-1:0];
          qb_q[k]  <= {qin[STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = ge_q[STEPS-1] ? {1'b1, {STEPS{1'b0}}} : {1'b0, qb_q[STEPS-1]};

endmodule

// ===== hdl/ssdg_sqrt.sv =====
// Pipelined integer square root, one result bit per stage: r = floor(sqrt(x)).
// No package dependency.
`timescale 1ns / 1ps

module ssdg_sqrt #(
  parameter int STEPS = 31
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*STEPS-1:0] x_i,
  output logic [STEPS-1:0]   r_o
);

  localparam int XW = 2 * STEPS;

  logic [XW-1:0] x_q   [STEPS];
  logic [XW-1:0] res_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    localparam logic [XW-1:0] Bit = XW'(1) << (2 * (STEPS - 1 - k));
    logic [XW-1:0] xin, rin, trial;
    if (k == 0) begin : g_first
      assign xin = x_i;
      assign rin = '0;
    end else begin : g_next
      assign xin = x_q[k-1];
      assign rin = res_q[k-1];
    end
    assign trial = rin + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (xin >= trial) begin
          x_q[k]   <= xin - trial;
          res_q[k] <= (rin >> 1) + Bit;
        end else begin
          x_q[k]   <= xin;
          res_q[k] <= rin >> 1;
        end
      end
    end
  end

  assign r_o = res_q[STEPS-1][STEPS-1:0];

endmodule

// ===== hdl/ssdg_front.sv =====
// Front end: accepts words, removes grid correction when degrid is set, forms saturated power, queues.
// Depends on ssdg_pkg.
`timescale 1ns / 1ps

module ssdg_front #(
  parameter int QDEPTH = ssdg_pkg::QDEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssdg_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  coef_re_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  coef_im_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  grid_re_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  grid_im_i,
  input  logic [ssdg_pkg::WGT_W-1:0]          sharpen_weight_i,
  input  logic [ssdg_pkg::WGT_W-1:0]          dehalo_weight_i,
  output logic                                hd_valid_o,
  output ssdg_pkg::ent_t                      hd_o,
  input  logic                                pop_i
);

  localparam int PW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNW = $clog2(QDEPTH + 1);
  localparam int CW  = ssdg_pkg::CORR_W;
  localparam int PWW = ssdg_pkg::PWR_W;

  logic                 en;
  logic                 full;
  logic                 f1_vld_q, f2_vld_q, f3_vld_q;
  ssdg_pkg::ent_t       f1_q, f2_q, f3_q, f1_d, f3_d;
  logic [2*CW-1:0]      sq_re_q, sq_im_q;
  logic [2*CW-1:0]      sq_re_d, sq_im_d;
  logic [2*CW:0]        psum;
  logic [CW-1:0]        ar, ai;
  logic                 push;

  ssdg_pkg::ent_t       mem_q [QDEPTH];
  logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0]       cnt_q;

  assign full       = (cnt_q == CNW'(QDEPTH));
  assign en         = !(f3_vld_q && full);
  assign in_ready_o = en;
  assign push       = en && f3_vld_q;

  always_comb begin
    f1_d      = '0;
    f1_d.g_re = cfg_i.degrid ? grid_re_i : '0;
    f1_d.g_im = cfg_i.degrid ? grid_im_i : '0;
    f1_d.c_re = {coef_re_i[ssdg_pkg::DATA_W-1], coef_re_i}
              - {f1_d.g_re[ssdg_pkg::DATA_W-1], f1_d.g_re};
    f1_d.c_im = {coef_im_i[ssdg_pkg::DATA_W-1], coef_im_i}
              - {f1_d.g_im[ssdg_pkg::DATA_W-1], f1_d.g_im};
    f1_d.sw   = sharpen_weight_i;
    f1_d.dw   = dehalo_weight_i;
  end

  assign ar      = f1_q.c_re[CW-1] ? CW'(-f1_q.c_re) : CW'(f1_q.c_re);
  assign ai      = f1_q.c_im[CW-1] ? CW'(-f1_q.c_im) : CW'(f1_q.c_im);
  assign sq_re_d = ar * ar;
  assign sq_im_d = ai * ai;
  assign psum    = {1'b0, sq_re_q} + {1'b0, sq_im_q};

  always_comb begin
    f3_d   = f2_q;
    f3_d.p = (psum[2*CW:PWW] != '0) ? {PWW{1'b1}} : psum[PWW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= in_valid_i;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q    <= f1_d;
      f2_q    <= f1_q;
      sq_re_q <= sq_re_d;
      sq_im_q <= sq_im_d;
      f3_q    <= f3_d;
    end
  end

  // word queue between front and back
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= f3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign hd_valid_o = (cnt_q != '0);
  assign hd_o       = mem_q[rd_ptr_q];

endmodule

// ===== hdl/ssdg_back.sv =====
// Back end: factor pipeline (fraction dividers, square root, gain products) and output register.
// Depends on ssdg_pkg, ssdg_div, ssdg_sqrt.
`timescale 1ns / 1ps

module ssdg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssdg_pkg::cfg_t                      cfg_i,
  input  logic                                hd_valid_i,
  input  ssdg_pkg::ent_t                      hd_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ssdg_pkg::DATA_W-1:0]  out_re_o,
  output logic signed [ssdg_pkg::DATA_W-1:0]  out_im_o
);

  localparam int DS   = ssdg_pkg::DIV_STEPS;
  localparam int SS   = ssdg_pkg::SQRT_STEPS;
  localparam int NSTG = 4 + DS + 1 + SS + 5;
  localparam int CW   = ssdg_pkg::CORR_W;
  localparam int GW   = ssdg_pkg::DATA_W;
  localparam int PWW  = ssdg_pkg::PWR_W;
  localparam int DWS  = ssdg_pkg::DIV_W_S;
  localparam int DWD  = ssdg_pkg::DIV_W_D;

  typedef struct packed {
    logic signed [CW-1:0] c_re;
    logic signed [CW-1:0] c_im;
    logic signed [GW-1:0] g_re;
    logic signed [GW-1:0] g_im;
    logic signed [32:0]   s1;
    logic                 sok;
    logic                 dz;
  } side_t;

  logic             be;
  logic [NSTG-1:0]  vld_q;

  // front stages
  ssdg_pkg::ent_t   e0_q, e1_q;
  side_t            sd1_q, sd2_q, sd3_q;
  side_t            sd1_d, sd2_d, sd3_d;
  logic [DWS-1:0]   dl1_q, dh1_q, dl2_q, dh2_q, dl3_q, dh3_q;
  logic [DWS-1:0]   d11_q, d12_q;
  logic [31:0]      dg1_q;
  logic [PWW-1:0]   p2_q, p3_q;
  logic [PWW-1:0]   sh3_q;
  logic [DWS-1:0]   d13_q;
  logic [DWD-1:0]   den3_q;
  logic [55:0]      hi2_q, lo2_q;
  logic [56:0]      qsum;
  logic [DWD-1:0]   den;

  // divider outputs and delay lines
  logic [DS:0]      qa, qb, qd;
  side_t            dl_q [DS];
  side_t            s34_q;
  logic [61:0]      ab34_q;
  logic [28:0]      d34_q;
  side_t            sl_q [SS];
  logic [28:0]      dd_q [SS];
  logic [SS-1:0]    r;

  // tail stages
  side_t            t66_q, t67_q, t68_q, t69_q, t70_q;
  logic [28:0]      d66_q, d67_q;
  logic [62:0]      p66_q;
  logic             n66_q;
  logic signed [37:0] s67_q;
  logic [65:0]      p68_q;
  logic             n68_q;
  logic signed [38:0] f69_q;
  logic [62:0]      pr70_q, pi70_q;
  logic             nr70_q, ni70_q;

  logic [31:0]      s1mag;
  logic [63:0]      m1sum;
  logic [37:0]      m1;
  logic [36:0]      smag;
  logic [66:0]      m2sum;
  logic [37:0]      m2;
  logic [37:0]      fmag;
  logic [CW-1:0]    crmag, cimag;
  logic [63:0]      rsum, isum;
  logic signed [35:0] vre, vim;

  assign be    = !out_valid_o || out_ready_i;
  assign pop_o = be && hd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else if (be) begin
      vld_q       <= {vld_q[NSTG-2:0], pop_o};
      out_valid_o <= vld_q[NSTG-1];
    end
  end

  assign qsum = {1'b0, hi2_q} + 57'(lo2_q[55:24]);
  assign den  = DWD'({1'b0, d12_q}) + qsum[56:2];

  always_comb begin
    sd1_d.c_re = e0_q.c_re;
    sd1_d.c_im = e0_q.c_im;
    sd1_d.g_re = e0_q.g_re;
    sd1_d.g_im = e0_q.g_im;
    sd1_d.s1   = 33'(cfg_i.sharpen_gain * $signed({1'b0, e0_q.sw}));
    sd1_d.sok  = 1'b0;
    sd1_d.dz   = 1'b0;
    sd2_d      = sd1_q;
    sd2_d.sok  = (dl1_q != '0) && (dh1_q != '0);
    sd3_d      = sd2_q;
    sd3_d.dz   = (den == '0);
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      e0_q <= hd_i;
      // E1: sums and weight products
      e1_q  <= e0_q;
      dl1_q <= {1'b0, e0_q.p} + {1'b0, cfg_i.sigma_low};
      dh1_q <= {1'b0, e0_q.p} + {1'b0, cfg_i.sigma_high};
      d11_q <= {1'b0, e0_q.p} + {1'b0, cfg_i.halo};
      dg1_q <= cfg_i.dehalo_gain * e0_q.dw;
      sd1_q <= sd1_d;
      // E2: dehalo product halves
      sd2_q <= sd2_d;
      dl2_q <= dl1_q;
      dh2_q <= dh1_q;
      d12_q <= d11_q;
      p2_q  <= e1_q.p;
      hi2_q <= dg1_q * e1_q.p[47:24];
      lo2_q <= dg1_q * e1_q.p[23:0];
      // E3: dehalo denominator
      sd3_q  <= sd3_d;
      dl3_q  <= dl2_q;
      dh3_q  <= dh2_q;
      p3_q   <= p2_q;
      sh3_q  <= cfg_i.sigma_high;
      d13_q  <= d12_q;
      den3_q <= den;
    end
  end

  ssdg_div #(.W(DWS), .STEPS(DS)) u_div_a (
    .clk_i (clk_i), .en_i (be), .n_i ({1'b0, p3_q}), .d_i (dl3_q), .q_o (qa)
  );
  ssdg_div #(.W(DWS), .STEPS(DS)) u_div_b (
    .clk_i (clk_i), .en_i (be), .n_i ({1'b0, sh3_q}), .d_i (dh3_q), .q_o (qb)
  );
  ssdg_div #(.W(DWD), .STEPS(DS)) u_div_d (
    .clk_i (clk_i), .en_i (be), .n_i (DWD'(d13_q)), .d_i (den3_q), .q_o (qd)
  );

  always_ff @(posedge clk_i) begin
    if (be) begin
      dl_q[0] <= sd3_q;
      for (int k = 1; k < DS; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
      s34_q  <= dl_q[DS-1];
      ab34_q <= 62'(qa * qb);
      d34_q  <= dl_q[DS-1].dz ? 29'(1 << 28) : qd[DS:2];
      sl_q[0] <= s34_q;
      dd_q[0] <= d34_q;
      for (int k = 1; k < SS; k++) begin
        sl_q[k] <= sl_q[k-1];
        dd_q[k] <= dd_q[k-1];
      end
    end
  end

  ssdg_sqrt #(.STEPS(SS)) u_sqrt (
    .clk_i (clk_i), .en_i (be), .x_i ({ab34_q[61:30], 30'd0}), .r_o (r)
  );

  always_comb begin
    s1mag = sl_q[SS-1].s1[32] ? 32'(-sl_q[SS-1].s1) : 32'(sl_q[SS-1].s1);
    m1sum = {1'b0, p66_q} + 64'(1 << 25);
    m1    = m1sum[63:26];
    smag  = s67_q[37] ? 37'(-s67_q) : 37'(s67_q);
    m2sum = {1'b0, p68_q} + 67'(1 << 27);
    m2    = m2sum[65:28];
    fmag  = f69_q[38] ? 38'(-f69_q) : 38'(f69_q);
    crmag = t69_q.c_re[CW-1] ? CW'(-t69_q.c_re) : CW'(t69_q.c_re);
    cimag = t69_q.c_im[CW-1] ? CW'(-t69_q.c_im) : CW'(t69_q.c_im);
    rsum  = {1'b0, pr70_q} + 64'(1 << 29);
    isum  = {1'b0, pi70_q} + 64'(1 << 29);
    vre   = (nr70_q ? -$signed({2'b0, rsum[63:30]}) : $signed({2'b0, rsum[63:30]}))
          + 36'(t70_q.g_re);
    vim   = (ni70_q ? -$signed({2'b0, isum[63:30]}) : $signed({2'b0, isum[63:30]}))
          + 36'(t70_q.g_im);
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      // sharpen term product
      t66_q <= sl_q[SS-1];
      d66_q <= dd_q[SS-1];
      p66_q <= s1mag * r;
      n66_q <= sl_q[SS-1].s1[32];
      // sharpen factor
      t67_q <= t66_q;
      d67_q <= d66_q;
      if (!t66_q.sok) begin
        s67_q <= 38'sd1 <<< 30;
      end else if (n66_q) begin
        s67_q <= (38'sd1 <<< 30) - $signed(m1);
      end else begin
        s67_q <= (38'sd1 <<< 30) + $signed(m1);
      end
      // combined factor product
      t68_q <= t67_q;
      p68_q <= 66'(smag * d67_q);
      n68_q <= s67_q[37];
      // combined factor
      t69_q <= t68_q;
      f69_q <= n68_q ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
      // coefficient products
      t70_q  <= t69_q;
      pr70_q <= crmag * fmag;
      pi70_q <= cimag * fmag;
      nr70_q <= t69_q.c_re[CW-1] ^ f69_q[38];
      ni70_q <= t69_q.c_im[CW-1] ^ f69_q[38];
      // round, restore grid, saturate
      if (vre > 36'sd8388607) begin
        out_re_o <= 24'sh7FFFFF;
      end else if (vre < -36'sd8388608) begin
        out_re_o <= 24'sh800000;
      end else begin
        out_re_o <= vre[GW-1:0];
      end
      if (vim > 36'sd8388607) begin
        out_im_o <= 24'sh7FFFFF;
      end else if (vim < -36'sd8388608) begin
        out_im_o <= 24'sh800000;
      end else begin
        out_im_o <= vim[GW-1:0];
      end
    end
  end

endmodule

// ===== hdl/spectral_sharpen_dehalo_gain.sv =====
// Top level: configuration registers, APB port, front end and back end.
// Depends on ssdg_pkg, ssdg_front, ssdg_back.
//
//   channel | handshake                 | word
//   in      | in_valid_i / in_ready_o   | coef_re/im, grid_re/im, sharpen/dehalo_weight
//   out     | out_valid_o / out_ready_i | out_re, out_im
//   cfg     | psel, penable, pwrite     | paddr, pwdata -> prdata, pready
//
// One word per cycle in and out while neither side stalls; an accepted word passes
// 3 front stages, the queue and 71 back stages; the back depth is set by the
// 30-step fraction dividers and the 31-step root pipeline.
// The back pipeline and output register advance together and freeze while the output stalls.
// The front keeps accepting into a QDEPTH-word queue until that fills.
// Reset clears control and configuration registers only; no clearing pass.
`timescale 1ns / 1ps

module spectral_sharpen_dehalo_gain #(
  parameter int QDEPTH = ssdg_pkg::QDEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssdg_pkg::ADDR_W-1:0]         paddr,
  input  logic [ssdg_pkg::APB_DW-1:0]         pwdata,
  output logic [ssdg_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  coef_re_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  coef_im_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  grid_re_i,
  input  logic signed [ssdg_pkg::DATA_W-1:0]  grid_im_i,
  input  logic [ssdg_pkg::WGT_W-1:0]          sharpen_weight_i,
  input  logic [ssdg_pkg::WGT_W-1:0]          dehalo_weight_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ssdg_pkg::DATA_W-1:0]  out_re_o,
  output logic signed [ssdg_pkg::DATA_W-1:0]  out_im_o
);

  ssdg_pkg::cfg_t     cfg_q;
  ssdg_pkg::reg_idx_e idx;
  logic               wr;
  logic               hd_valid;
  ssdg_pkg::ent_t     hd;
  logic               pop;

  assign pready = 1'b1;
  assign idx    = ssdg_pkg::reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr) begin
      case (idx)
        ssdg_pkg::REG_SIGMA_LOW:  cfg_q.sigma_low    <= pwdata[47:0];
        ssdg_pkg::REG_SIGMA_HIGH: cfg_q.sigma_high   <= pwdata[47:0];
        ssdg_pkg::REG_SHARPEN:    cfg_q.sharpen_gain <= pwdata[15:0];
        ssdg_pkg::REG_DEHALO:     cfg_q.dehalo_gain  <= pwdata[15:0];
        ssdg_pkg::REG_HALO:       cfg_q.halo         <= pwdata[47:0];
        ssdg_pkg::REG_DEGRID:     cfg_q.degrid       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ssdg_pkg::REG_SIGMA_LOW:  prdata = 64'(cfg_q.sigma_low);
      ssdg_pkg::REG_SIGMA_HIGH: prdata = 64'(cfg_q.sigma_high);
      ssdg_pkg::REG_SHARPEN:    prdata = 64'(cfg_q.sharpen_gain);
      ssdg_pkg::REG_DEHALO:     prdata = 64'(cfg_q.dehalo_gain);
      ssdg_pkg::REG_HALO:       prdata = 64'(cfg_q.halo);
      ssdg_pkg::REG_DEGRID:     prdata = 64'(cfg_q.degrid);
      default:                  prdata = '0;
    endcase
  end

  ssdg_front #(.QDEPTH(QDEPTH)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .coef_re_i        (coef_re_i),
    .coef_im_i        (coef_im_i),
    .grid_re_i        (grid_re_i),
    .grid_im_i        (grid_im_i),
    .sharpen_weight_i (sharpen_weight_i),
    .dehalo_weight_i  (dehalo_weight_i),
    .hd_valid_o       (hd_valid),
    .hd_o             (hd),
    .pop_i            (pop)
  );

  ssdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .hd_valid_i  (hd_valid),
    .hd_i        (hd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> hd_valid) else $error("pop from empty queue");

  a_stall_needs_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> hd_valid) else $error("front stalled with empty queue");

  a_back_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !pop) else $error("back popped while output stalled");

endmodule

// ===== sim/spectral_sharpen_dehalo_gain_tb.sv =====
// Self-checking testbench for spectral_sharpen_dehalo_gain: random and directed words
// under several register settings, checked against a bit-exact gain predictor.
// Depends on ssdg_pkg and the spectral_sharpen_dehalo_gain RTL.
`timescale 1ns / 1ps

module spectral_sharpen_dehalo_gain_tb;

  typedef struct {
    logic signed [23:0] c_re, c_im, g_re, g_im;
    logic [15:0]        sw, dw;
  } coef_t;

  typedef struct {
    logic signed [23:0] re, im;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ssdg_pkg::ADDR_W-1:0] paddr = '0;
  logic [ssdg_pkg::APB_DW-1:0] pwdata = '0;
  logic [ssdg_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [23:0] coef_re_i = '0, coef_im_i = '0, grid_re_i = '0, grid_im_i = '0;
  logic [15:0] sharpen_weight_i = '0, dehalo_weight_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [23:0] out_re_o, out_im_o;

  // register copies for prediction
  logic [47:0]        sig_lo = '0, sig_hi = '0, halo_th = '0;
  logic signed [15:0] sharp_g = '0;
  logic [15:0]        dehalo_g = '0;
  logic               degrid = 1'b0;

  coef_t pend_q[$];
  res_t  want_q[$];
  int    n_accepted = 0;
  int    n_err = 0;
  logic  quiet = 1'b0;
  logic  hold_rx = 1'b0;

  spectral_sharpen_dehalo_gain u_dut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("** spectral_sharpen_dehalo_gain: FAILED **");
    $finish;
  end

  function automatic longint unsigned frac_fix(longint unsigned n, longint unsigned d,
                                               int bits);
    longint unsigned rem, q;
    rem = n;
    q = 0;
    if (n >= d) return 64'd1 << bits;
    for (int i = 0; i < bits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint rnd_mul(longint a, longint b, int sh);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic res_t scale_coef(coef_t w);
    longint cre, cim, gre, gim, s, d, f;
    longint unsigned ar, ai, p, a, b, s2, r, d1, dg, hi, lo, q, denom;
    res_t o;
    gre = degrid ? longint'(w.g_re) : 0;
    gim = degrid ? longint'(w.g_im) : 0;
    cre = longint'(w.c_re) - gre;
    cim = longint'(w.c_im) - gim;
    ar = (cre < 0) ? -cre : cre;
    ai = (cim < 0) ? -cim : cim;
    p = ar * ar + ai * ai;
    if (p > 64'hFFFF_FFFF_FFFF) p = 64'hFFFF_FFFF_FFFF;
    s = longint'(1) << 30;
    if (p + sig_lo != 0 && p + sig_hi != 0) begin
      a = frac_fix(p, p + sig_lo, 30);
      b = frac_fix(sig_hi, p + sig_hi, 30);
      s2 = (a * b) >> 30;
      r = root64(s2 << 30);
      s = s + rnd_mul(longint'(sharp_g) * longint'(w.sw), longint'(r), 26);
    end
    d1 = p + halo_th;
    dg = longint'(dehalo_g) * longint'(w.dw);
    hi = dg * (p >> 24);
    lo = dg * (p & 64'hFF_FFFF);
    q = (hi >> 2) + ((((hi & 64'd3) << 24) + lo) >> 26);
    denom = d1 + q;
    d = (denom == 0) ? (longint'(1) << 28) : longint'(frac_fix(d1, denom, 28));
    f = rnd_mul(s, d, 28);
    o.re = clamp24(rnd_mul(cre, f, 30) + gre);
    o.im = clamp24(rnd_mul(cim, f, 30) + gim);
    return o;
  endfunction

  function automatic logic signed [23:0] pick24();
    case ($urandom_range(0, 5))
      0: return 24'(signed'($urandom_range(0, 8191)) - 4096);
      1: return $urandom_range(0, 1) ? 24'sd8388607 : -24'sd8388608;
      2: return 24'(signed'($urandom_range(0, 524287)) - 262144);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 16384));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick48();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return 48'($urandom_range(0, 32'hFFFF_FFFF));
      default: return {16'($urandom), 32'($urandom)} >> $urandom_range(0, 47);
    endcase
  endfunction

  task automatic push_word(logic signed [23:0] cr, ci, gr, gi, logic [15:0] sw, dw);
    coef_t w;
    w.c_re = cr; w.c_im = ci; w.g_re = gr; w.g_im = gi; w.sw = sw; w.dw = dw;
    pend_q.push_back(w);
  endtask

  task automatic push_random(int n);
    repeat (n) push_word(pick24(), pick24(), pick24(), pick24(), pick16(), pick16());
  endtask

  task automatic push_edges();
    push_word(0, 0, 0, 0, 0, 0);
    push_word(24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607, 16'hFFFF, 16'hFFFF);
    push_word(-24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608, 0, 16'hFFFF);
    push_word(24'sd8388607, 24'sd8388607, 24'sd8388607, 24'sd8388607, 16'hFFFF, 0);
    push_word(24'sd65536, -24'sd65536, 24'sd1, -24'sd1, 16'h4000, 16'h4000);
    push_word(24'sd1, 0, -24'sd1, 0, 16'hFFFF, 16'hFFFF);
    push_word(24'sd100, 24'sd100, 24'sd100, 24'sd100, 16'hFFFF, 16'hFFFF);
    push_word(-24'sd1, -24'sd1, 0, 0, 16'h5555, 16'hAAAA);
    push_word(24'sd5000000, 24'sd5000000, -24'sd5000000, -24'sd5000000, 16'hFFFF, 0);
  endtask

  task automatic write_reg(ssdg_pkg::reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ssdg_pkg::REG_SIGMA_LOW:  sig_lo = val[47:0];
      ssdg_pkg::REG_SIGMA_HIGH: sig_hi = val[47:0];
      ssdg_pkg::REG_SHARPEN:    sharp_g = val[15:0];
      ssdg_pkg::REG_DEHALO:     dehalo_g = val[15:0];
      ssdg_pkg::REG_HALO:       halo_th = val[47:0];
      ssdg_pkg::REG_DEGRID:     degrid = val[0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [47:0] lo, hi, logic [15:0] sg, dg, logic [47:0] ht, logic en);
    write_reg(ssdg_pkg::REG_SIGMA_LOW, lo);
    write_reg(ssdg_pkg::REG_SIGMA_HIGH, hi);
    write_reg(ssdg_pkg::REG_SHARPEN, sg);
    write_reg(ssdg_pkg::REG_DEHALO, dg);
    write_reg(ssdg_pkg::REG_HALO, ht);
    write_reg(ssdg_pkg::REG_DEGRID, en);
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || in_valid_i || want_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  // sender
  coef_t cur;
  int    tx_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        want_q.push_back(scale_coef(cur));
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur = pend_q.pop_front();
          coef_re_i <= cur.c_re; coef_im_i <= cur.c_im;
          grid_re_i <= cur.g_re; grid_im_i <= cur.g_im;
          sharpen_weight_i <= cur.sw; dehalo_weight_i <= cur.dw;
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int   rx_stall = 0;
  res_t exp_w;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (want_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected word re=%0d im=%0d", out_re_o, out_im_o);
        end else begin
          exp_w = want_q.pop_front();
          if (exp_w.re !== out_re_o || exp_w.im !== out_im_o) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                       exp_w.re, exp_w.im, out_re_o, out_im_o);
          end
        end
      end
      if (rx_stall > 0) rx_stall--;
      else if (!quiet && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 11);
      out_ready_i <= !hold_rx && rx_stall == 0;
    end
  end

  // long output back-pressure to fill the queue
  initial begin
    wait (n_accepted >= 250);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset config: pass-through, zero denominators
    push_edges();
    push_random(60);
    drain();
    // moderate settings with degrid
    set_all(48'h0_4000_0000, 48'h4_0000_0000, 16'h1000, 16'h0800, 48'h1_0000_0000, 1'b1);
    push_edges();
    push_random(150);
    drain();
    // extremes
    set_all(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h8000, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
            1'b1);
    push_edges();
    push_random(80);
    drain();
    set_all(0, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 16'hFFFF, 0, 1'b0);
    push_edges();
    push_random(80);
    drain();
    repeat (3) begin
      set_all(pick48(), pick48(), 16'($urandom), pick16(), pick48(), 1'($urandom));
      push_random(80);
      drain();
    end
    quiet <= 1'b1;
    set_all(pick48(), pick48(), 16'($urandom), pick16(), pick48(), 1'b1);
    push_random(80);
    drain();
    if (n_err == 0 && want_q.size() == 0) begin
      $display("** spectral_sharpen_dehalo_gain: PASSED **");
    end else begin
      $display("** spectral_sharpen_dehalo_gain: FAILED **");
    end
    $finish;
  end

endmodule
